// File: hdl/ppe_pkg.sv
`timescale 1ns / 1ps
package ppe_pkg;

   localparam int SEQ_MAX_LEN_DEF = 16;
   localparam int VALUE_W         = 16;
   localparam int OP_W            = 4;

   localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
   localparam logic [OP_W-1:0] OP_STORE     = 4'd1;
   localparam logic [OP_W-1:0] OP_INIT      = 4'd2;
   localparam logic [OP_W-1:0] OP_RD_HI     = 4'd3;
   localparam logic [OP_W-1:0] OP_RD_LO     = 4'd4;
   localparam logic [OP_W-1:0] OP_RIGHT     = 4'd5;
   localparam logic [OP_W-1:0] OP_PIVOT     = 4'd6;
   localparam logic [OP_W-1:0] OP_WRAP      = 4'd7;
   localparam logic [OP_W-1:0] OP_DEC_HI    = 4'd8;
   localparam logic [OP_W-1:0] OP_SWAP1     = 4'd9;
   localparam logic [OP_W-1:0] OP_SWAP2     = 4'd10;
   localparam logic [OP_W-1:0] OP_RD_SAVE   = 4'd11;
   localparam logic [OP_W-1:0] OP_WR_LO     = 4'd12;
   localparam logic [OP_W-1:0] OP_WR_HI     = 4'd13;
   localparam logic [OP_W-1:0] OP_EMIT_INIT = 4'd14;
   localparam logic [OP_W-1:0] OP_EMIT      = 4'd15;

   typedef struct packed {
      logic signed [VALUE_W-1:0] elem_value;
      logic                      elem_last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic                      out_last;
      logic                      wrapped;
      logic                      overflow;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic cnt_one;
      logic desc;
      logic less;
      logic lo_lt_hi;
      logic lo_zero;
      logic at_last;
      logic out_free;
   } sts_type;

endpackage

// File: hdl/ppe_ctrl.sv
`timescale 1ns / 1ps
module ppe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   input  ppe_pkg::sts_type sts,
   output ppe_pkg::cmd_type cmd
);
   import ppe_pkg::*;

   localparam logic [4:0] S_LOAD   = 5'd0;
   localparam logic [4:0] S_INIT   = 5'd1;
   localparam logic [4:0] S_D_RD0  = 5'd2;
   localparam logic [4:0] S_D_RD1  = 5'd3;
   localparam logic [4:0] S_D_RD   = 5'd4;
   localparam logic [4:0] S_D_CMP  = 5'd5;
   localparam logic [4:0] S_P_RD   = 5'd6;
   localparam logic [4:0] S_P_CMP  = 5'd7;
   localparam logic [4:0] S_SWAP2  = 5'd8;
   localparam logic [4:0] S_R_CHK  = 5'd9;
   localparam logic [4:0] S_R_RDLO = 5'd10;
   localparam logic [4:0] S_R_RDHI = 5'd11;
   localparam logic [4:0] S_R_WLO  = 5'd12;
   localparam logic [4:0] S_R_WHI  = 5'd13;
   localparam logic [4:0] S_E_INIT = 5'd14;
   localparam logic [4:0] S_E_RD   = 5'd15;
   localparam logic [4:0] S_E_LD   = 5'd16;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NOP;
      req_ready = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_STORE;
               if (req_last) begin
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            cmd.op   = OP_INIT;
            state_in = sts.cnt_one ? S_R_CHK : S_D_RD0;
         end
         S_D_RD0: begin
            cmd.op   = OP_RD_HI;
            state_in = S_D_RD1;
         end
         S_D_RD1: begin
            cmd.op   = OP_RIGHT;
            state_in = S_D_RD;
         end
         S_D_RD: begin
            cmd.op   = OP_RD_LO;
            state_in = S_D_CMP;
         end
         S_D_CMP: begin
            if (sts.desc) begin
               cmd.op   = OP_PIVOT;
               state_in = S_P_RD;
            end else if (sts.lo_zero) begin
               cmd.op   = OP_WRAP;
               state_in = S_R_CHK;
            end else begin
               cmd.op   = OP_RIGHT;
               state_in = S_D_RD;
            end
         end
         S_P_RD: begin
            cmd.op   = OP_RD_HI;
            state_in = S_P_CMP;
         end
         S_P_CMP: begin
            if (sts.less) begin
               cmd.op   = OP_SWAP1;
               state_in = S_SWAP2;
            end else begin
               cmd.op   = OP_DEC_HI;
               state_in = S_P_RD;
            end
         end
         S_SWAP2: begin
            cmd.op   = OP_SWAP2;
            state_in = S_R_CHK;
         end
         S_R_CHK: begin
            state_in = sts.lo_lt_hi ? S_R_RDLO : S_E_INIT;
         end
         S_R_RDLO: begin
            cmd.op   = OP_RD_LO;
            state_in = S_R_RDHI;
         end
         S_R_RDHI: begin
            cmd.op   = OP_RD_SAVE;
            state_in = S_R_WLO;
         end
         S_R_WLO: begin
            cmd.op   = OP_WR_LO;
            state_in = S_R_WHI;
         end
         S_R_WHI: begin
            cmd.op   = OP_WR_HI;
            state_in = S_R_CHK;
         end
         S_E_INIT: begin
            cmd.op   = OP_EMIT_INIT;
            state_in = S_E_RD;
         end
         S_E_RD: begin
            cmd.op   = OP_RD_LO;
            state_in = S_E_LD;
         end
         S_E_LD: begin
            if (sts.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = sts.at_last ? S_LOAD : S_E_RD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/ppe_dp.sv
`timescale 1ns / 1ps
module ppe_dp #(
   parameter int MAX_LEN = ppe_pkg::SEQ_MAX_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  ppe_pkg::req_type req,
   input  ppe_pkg::cmd_type cmd,
   output ppe_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ppe_pkg::rsp_type rsp
);
   import ppe_pkg::*;

   localparam int IW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);

   logic signed [VALUE_W-1:0] mem [MAX_LEN];

   logic [CW-1:0]             count_ff, count_in;
   logic                      drop_ff, drop_in;
   logic                      wrap_ff, wrap_in;
   logic [IW-1:0]             lo_ff, lo_in;
   logic [IW-1:0]             hi_ff, hi_in;
   logic signed [VALUE_W-1:0] rd_ff;
   logic signed [VALUE_W-1:0] right_ff, right_in;
   logic signed [VALUE_W-1:0] piv_ff, piv_in;
   logic signed [VALUE_W-1:0] tmp_ff, tmp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      rd_en;
   logic [IW-1:0]             rd_addr;
   logic                      wr_en;
   logic [IW-1:0]             wr_addr;
   logic signed [VALUE_W-1:0] wr_data;
   logic [IW-1:0]             last_idx;
   logic                      has_room;

   assign last_idx = IW'(count_ff - CW'(1));
   assign has_room = (count_ff < CW'(MAX_LEN));

   assign sts.cnt_one  = (count_ff == CW'(1));
   assign sts.desc     = (rd_ff > right_ff);
   assign sts.less     = (rd_ff < piv_ff);
   assign sts.lo_lt_hi = (lo_ff < hi_ff);
   assign sts.lo_zero  = (lo_ff == '0);
   assign sts.at_last  = (lo_ff == last_idx);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      count_in     = count_ff;
      drop_in      = drop_ff;
      wrap_in      = wrap_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      right_in     = right_ff;
      piv_in       = piv_ff;
      tmp_in       = tmp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_en        = 1'b0;
      rd_addr      = lo_ff;
      wr_en        = 1'b0;
      wr_addr      = lo_ff;
      wr_data      = rd_ff;
      case (cmd.op)
         OP_STORE: begin
            if (has_room) begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[IW-1:0];
               wr_data  = req.elem_value;
               count_in = count_ff + CW'(1);
            end else begin
               drop_in = 1'b1;
            end
         end
         OP_INIT: begin
            lo_in   = last_idx;
            hi_in   = last_idx;
            wrap_in = sts.cnt_one;
         end
         OP_RD_HI: begin
            rd_en   = 1'b1;
            rd_addr = hi_ff;
         end
         OP_RD_LO: begin
            rd_en = 1'b1;
         end
         OP_RIGHT: begin
            right_in = rd_ff;
            lo_in    = lo_ff - IW'(1);
         end
         OP_PIVOT: begin
            piv_in = rd_ff;
         end
         OP_WRAP: begin
            wrap_in = 1'b1;
         end
         OP_DEC_HI: begin
            hi_in = hi_ff - IW'(1);
         end
         OP_SWAP1: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = piv_ff;
         end
         OP_SWAP2: begin
            wr_en = 1'b1;
            lo_in = lo_ff + IW'(1);
            hi_in = last_idx;
         end
         OP_RD_SAVE: begin
            rd_en   = 1'b1;
            rd_addr = hi_ff;
            tmp_in  = rd_ff;
         end
         OP_WR_LO: begin
            wr_en = 1'b1;
         end
         OP_WR_HI: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = tmp_ff;
            lo_in   = lo_ff + IW'(1);
            hi_in   = hi_ff - IW'(1);
         end
         OP_EMIT_INIT: begin
            lo_in = '0;
         end
         OP_EMIT: begin
            rsp_in.out_value = rd_ff;
            rsp_in.out_last  = sts.at_last;
            rsp_in.wrapped   = wrap_ff;
            rsp_in.overflow  = drop_ff;
            rsp_valid_in     = 1'b1;
            lo_in            = lo_ff + IW'(1);
            if (sts.at_last) begin
               count_in = '0;
               drop_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wrap_ff  <= wrap_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      right_ff <= right_in;
      piv_ff   <= piv_in;
      tmp_ff   <= tmp_in;
      rsp_ff   <= rsp_in;
   end

endmodule

// File: hdl/previous_permutation_engine.sv
`timescale 1ns / 1ps
// Previous lexicographic permutation of a stored sequence of signed 16-bit values.
// req channel: one element per item, elem_last marks the final element of a sequence.
//   Elements are taken at one per cycle while loading; those beyond MAX_LEN are dropped
//   and reported through the overflow flag on every result item of that sequence.
// rsp channel: after the last element the whole permuted sequence comes out in order,
//   one item per stored element, out_last on the final one. A non-decreasing input wraps
//   to its reversal and sets wrapped on every item.
// Before the first result the engine scans from the end for the descent, then from the end
//   for the swap partner, swaps the two and reverses the suffix pair by pair; with no
//   descent it reverses the whole sequence instead.
// Every step, each result item included, goes through the single read port of the
//   sequence store, whose read data is registered.
// req_ready is high only while loading; a new sequence is taken once the last
//   result sits in the output register.
// The output register holds its item while rsp_ready is low, and emission pauses.
// Reset empties the store count, clears the overflow flag and drops a pending result.
module previous_permutation_engine #(
   parameter int MAX_LEN = ppe_pkg::SEQ_MAX_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ppe_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ppe_pkg::rsp_type rsp
);
   import ppe_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ppe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req.elem_last),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ppe_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   a_no_load_mid_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.out_last |-> !req_ready)
      else $error("input taken while a sequence is still being emitted");

   a_flags_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp.out_last |=> !rsp_valid ||
         (rsp.wrapped == $past(rsp.wrapped) && rsp.overflow == $past(rsp.overflow)))
      else $error("sequence flags changed within one emitted sequence");

   a_swap_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_SWAP1 |=> cmd.op == OP_SWAP2)
      else $error("swap not completed");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

   localparam int MAX_LEN     = ppe_pkg::SEQ_MAX_LEN_DEF;
   localparam int IDLE_LIMIT  = 5000;
   localparam int RANDOM_ITEMS = 280;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ppe_pkg::req_type req       = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ppe_pkg::rsp_type rsp;

   ppe_pkg::req_type pending_elems[$];
   ppe_pkg::rsp_type expected_outputs[$];
   ppe_pkg::rsp_type want;

   logic signed [15:0] perm_store [MAX_LEN];
   int                 perm_count   = 0;
   logic               perm_dropped = 1'b0;

   int items_planned  = 0;
   int items_accepted = 0;
   int results_seen   = 0;
   int mismatch_count = 0;
   int seq_total      = 0;
   int wrap_total     = 0;
   int drop_total     = 0;

   int burst_left = 0;
   int gap_left   = 0;

   int   rx_phase  = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;

   int idle_cycles = 0;

   previous_permutation_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void flip_span(input int lo, input int hi);
      logic signed [15:0] t;
      while (lo < hi) begin
         t              = perm_store[lo];
         perm_store[lo] = perm_store[hi];
         perm_store[hi] = t;
         lo++;
         hi--;
      end
   endfunction

   task automatic absorb_element(input ppe_pkg::req_type it);
      int                 n;
      int                 i;
      int                 p;
      int                 j;
      int                 k;
      logic signed [15:0] t;
      logic               wrap;
      ppe_pkg::rsp_type   r;
      if (perm_count < MAX_LEN) begin
         perm_store[perm_count] = it.elem_value;
         perm_count++;
      end else begin
         perm_dropped = 1'b1;
      end
      if (it.elem_last) begin
         n    = perm_count;
         wrap = 1'b1;
         i    = n - 1;
         while (i > 0 && !(perm_store[i-1] > perm_store[i])) i--;
         if (i == 0) begin
            flip_span(0, n - 1);
         end else begin
            wrap = 1'b0;
            p    = i - 1;
            j    = n - 1;
            while (!(perm_store[j] < perm_store[p])) j--;
            t             = perm_store[p];
            perm_store[p] = perm_store[j];
            perm_store[j] = t;
            flip_span(p + 1, n - 1);
         end
         for (k = 0; k < n; k++) begin
            r.out_value = perm_store[k];
            r.out_last  = (k == n - 1);
            r.wrapped   = wrap;
            r.overflow  = perm_dropped;
            expected_outputs.push_back(r);
         end
         seq_total++;
         if (wrap) wrap_total++;
         if (perm_dropped) drop_total++;
         perm_count   = 0;
         perm_dropped = 1'b0;
      end
   endtask

   task automatic push_elem(input logic [15:0] v, input logic last);
      ppe_pkg::req_type it;
      it.elem_value = v;
      it.elem_last  = last;
      pending_elems.push_back(it);
      items_planned++;
   endtask

   // shape: 0 full range, 1 few distinct values, 2 non-decreasing, 3 non-increasing
   task automatic queue_sequence(input int len, input int shape);
      int acc;
      int k;
      acc = $urandom_range(0, 65535) - 32768;
      for (k = 0; k < len; k++) begin
         case (shape)
            0: acc = $urandom_range(0, 65535) - 32768;
            1: acc = $urandom_range(0, 4) - 2;
            2: begin
               acc = acc + $urandom_range(0, 3);
               if (acc > 32767) acc = 32767;
            end
            default: begin
               acc = acc - $urandom_range(0, 3);
               if (acc < -32768) acc = -32768;
            end
         endcase
         push_elem(acc[15:0], k == len - 1);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         gap_left   <= 0;
         burst_left <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (pending_elems.size() > 0) begin
            req       <= pending_elems.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
               gap_left   <= $urandom_range(0, 5);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_phase  <= 0;
         hold_left <= 0;
      end else begin
         rx_phase <= rx_phase + 1;
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (!hold_done && results_seen >= 40) begin
            rsp_ready <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
         end else begin
            case ((rx_phase >> 8) % 4)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ((rx_phase % 5) != 0);
               default: rsp_ready <= $urandom_range(0, 1);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            absorb_element(req);
            items_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_outputs.size() == 0) begin
               $error("unexpected result item: out_value %0d", rsp.out_value);
               mismatch_count++;
            end else begin
               want = expected_outputs.pop_front();
               if (rsp.out_value !== want.out_value) begin
                  $error("out_value: expected %0d, actual %0d", want.out_value,
                         rsp.out_value);
                  mismatch_count++;
               end
               if (rsp.out_last !== want.out_last) begin
                  $error("out_last: expected %0b, actual %0b", want.out_last, rsp.out_last);
                  mismatch_count++;
               end
               if (rsp.wrapped !== want.wrapped) begin
                  $error("wrapped: expected %0b, actual %0b", want.wrapped, rsp.wrapped);
                  mismatch_count++;
               end
               if (rsp.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, actual %0b", want.overflow, rsp.overflow);
                  mismatch_count++;
               end
            end
            results_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without an item", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      int k;
      int r;
      int len;
      push_elem(16'sh7fff, 1'b1);
      push_elem(16'sh8000, 1'b0);
      push_elem(16'sh7fff, 1'b1);
      push_elem(16'sh7fff, 1'b0);
      push_elem(16'sh8000, 1'b1);
      push_elem(16'sd2, 1'b0);
      push_elem(16'sd2, 1'b0);
      push_elem(16'sd1, 1'b1);
      // overrun the store, last two elements dropped
      for (k = 0; k < MAX_LEN + 2; k++)
         push_elem((k % 2) ? 16'(k * 1111) : 16'(-k * 2047), k == MAX_LEN + 1);
      k = items_planned;
      while (items_planned - k < RANDOM_ITEMS) begin
         r = $urandom_range(0, 19);
         if (r < 12) len = $urandom_range(1, 6);
         else if (r < 17) len = $urandom_range(7, 15);
         else if (r < 19) len = MAX_LEN;
         else len = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
         queue_sequence(len, $urandom_range(0, 3));
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted != items_planned) @(posedge clock);
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("%0d items in %0d sequences, %0d result items checked", items_accepted,
               seq_total, results_seen);
      $display("%0d sequences wrapped, %0d overran the store", wrap_total, drop_total);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
